/* sv/swz_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window z-score package
// Shared widths and the control bundle between the sequencer and the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package swz_pkg;
  localparam int SampleW   = 32;
  localparam int NormW     = 16;
  localparam int LenW      = 7;
  localparam int PosW      = 6;
  // Depth of the sample ring, a power of two so the pointers wrap freely.
  localparam int MaxWindow = 64;

  // Operations of the shared divide / square root unit.
  typedef enum logic [1:0] {
    OP_DIV_SIGNED = 2'd0,
    OP_DIV_VAR    = 2'd1,
    OP_SQRT       = 2'd2
  } unit_op_t;

  // Start request from the sequencer to the shared unit.
  typedef struct packed {
    logic        start;
    unit_op_t    op;
    logic [95:0] num;
    logic [63:0] den;
  } unit_req_t;

  // Result of the shared unit.
  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } unit_rsp_t;
endpackage
`default_nettype wire

/* sv/sliding_window_zscore.sv */
// Flow: a sample that closes no window is taken while idle; one that closes
//   a window holds off input until its last result word has left, as the
//   shared bit-serial unit works the mean, the variance, the root and each
//   output in turn (96 steps per division, 32 per root).
// Reset: synchronous; clears the write pointer, fill count and control, and sets the window length to 32.
`default_nettype none
// ----------------------------------------------------------------------------
// Sliding window z-score normalizer
// Keeps the last window_len Q16.16 samples in a ring and, per closed
// window, emits every sample's z-score in Q4.12 through a shared divider.
// ----------------------------------------------------------------------------
module sliding_window_zscore (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] sample
  input  wire logic        s_tuser,   // [0] series_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] norm_value, [21:16] position
  output logic             m_tlast    // last value of the window
);
  import swz_pkg::*;

  localparam int PW = $clog2(MaxWindow);
  localparam int CW = $clog2(MaxWindow + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM_RD, S_SUM, S_MEAN, S_VAR_RD, S_VAR, S_VDIV, S_SQRT,
    S_OUT_RD, S_OUT_DIV, S_OUT_WAIT, S_EMIT
  } state_t;

  state_t         state;
  logic [6:0]     window_len;
  logic [PW-1:0]  write_pointer;
  logic [CW-1:0]  fill_count;
  logic [31:0]    sample_ring [MaxWindow];
  logic [31:0]    rd_data;
  logic [PW-1:0]  rd_addr;
  logic [CW-1:0]  n;
  logic [CW-1:0]  idx;
  logic [PW-1:0]  start_ptr;
  logic [63:0]    sum;
  logic [63:0]    mean;
  logic [127:0]   sq_sum;
  logic [63:0]    sd;
  logic           neg;
  logic [63:0]    sq_mag;
  logic [65:0]    sq_prod;
  logic [127:0]   sq_total;
  logic [63:0]    mean_num;
  unit_req_t      req;
  unit_rsp_t      rsp;

  // Effective window length from the register, clamped to the ring.
  logic [CW-1:0] n_eff;
  logic [CW-1:0] fill_next;
  always_comb begin
    if (window_len == 7'd0) n_eff = CW'(1);
    else if (32'(window_len) > MaxWindow) n_eff = CW'(MaxWindow);
    else n_eff = CW'(window_len);
    fill_next = s_tuser ? CW'(1) :
                ((32'(fill_count) < MaxWindow) ? fill_count + CW'(1) : fill_count);
  end

  // Deviation of the sample just read, 33 bits signed held in 64.
  logic [63:0] dev;
  assign dev = {{32{rd_data[31]}}, rd_data} - mean;

  // Ring write and registered read.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) sample_ring[write_pointer] <= s_tdata;
    rd_data <= sample_ring[rd_addr];
  end
  assign rd_addr = start_ptr + idx[PW-1:0];

  // Squared deviation, registered before it is accumulated.
  assign sq_mag = dev[63] ? -dev : dev;
  always_ff @(posedge clk) sq_prod <= {33'd0, sq_mag[32:0]} * {33'd0, sq_mag[32:0]};
  assign sq_total = sq_sum + {62'd0, sq_prod};

  // Rounding numerator of the mean, 2*sum + n.
  assign mean_num = (sum << 1) + 64'(n);

  swz_divsqrt u_unit (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // Rounding and saturation of one output quotient.
  logic [63:0] q_round;
  logic [15:0] z;
  always_comb begin
    q_round = rsp.quo + ((rsp.rem >= (sd - (sd >> 1))) ? 64'd1 : 64'd0);
    if (neg) z = (q_round > 64'd32768) ? 16'h8000 : 16'(-q_round);
    else     z = (q_round > 64'd32767) ? 16'h7fff : q_round[15:0];
  end

  assign s_tready = (state == S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_len    <= 7'd32;
      write_pointer <= '0;
      fill_count    <= '0;
      m_tvalid      <= 1'b0;
      req.start     <= 1'b0;
    end else begin
      req.start <= 1'b0;
      if (cfg_we) window_len <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            write_pointer <= write_pointer + PW'(1);
            fill_count    <= fill_next;
            if (fill_next >= n_eff) begin
              n         <= n_eff;
              start_ptr <= write_pointer + PW'(1) - n_eff[PW-1:0];
              idx       <= '0;
              sum       <= '0;
              state     <= S_SUM_RD;
            end
          end
        end
        S_SUM_RD: begin
          idx   <= idx + CW'(1);
          state <= S_SUM;
        end
        S_SUM: begin
          sum <= sum + {{32{rd_data[31]}}, rd_data};
          if (idx == n) begin
            state <= S_MEAN;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_MEAN: begin
          // mean = floor((2*sum + n) / (2n)), signed handled by magnitude.
          req.start <= 1'b1;
          req.op    <= OP_DIV_SIGNED;
          req.den   <= {63'd0, 1'b0} | (64'(n) << 1);
          neg       <= mean_num[63];
          req.num   <= {32'd0, (mean_num[63] ? -mean_num : mean_num)};
          state     <= S_VAR_RD;
          idx       <= '0;
        end
        S_VAR_RD: begin
          if (rsp.done) begin
            // Floor for negatives: -(ceil(|t|/d)).
            mean   <= neg ? -(rsp.quo + ((rsp.rem != 0) ? 64'd1 : 64'd0)) : rsp.quo;
            sq_sum <= '0;
            idx    <= CW'(1);
            state  <= S_VAR;
          end
        end
        S_VAR: begin
          // Reads lead the product through the read-data and product registers.
          if (idx >= CW'(2)) sq_sum <= sq_total;
          if (idx == n) begin
            state <= S_VDIV;
          end
          idx <= idx + CW'(1);
        end
        S_VDIV: begin
          sq_sum    <= sq_total;
          req.start <= 1'b1;
          req.op    <= OP_DIV_VAR;
          req.num   <= sq_total[95:0];
          req.den   <= 64'(n);
          state     <= S_SQRT;
        end
        S_SQRT: begin
          if (rsp.done && !req.start) begin
            if (sd == 64'hffff_ffff_ffff_ffff) begin
              sd    <= (rsp.quo == 0) ? 64'd65536 : rsp.quo;
              idx   <= '0;
              state <= S_OUT_RD;
            end else begin
              sd        <= 64'hffff_ffff_ffff_ffff;
              req.start <= 1'b1;
              req.op    <= OP_SQRT;
              req.num   <= {32'd0, rsp.quo};
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_DIV;
        end
        S_OUT_DIV: begin
          neg       <= dev[63];
          req.start <= 1'b1;
          req.op    <= OP_DIV_SIGNED;
          req.num   <= {20'd0, (dev[63] ? -dev : dev), 12'd0};
          req.den   <= sd;
          state     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (rsp.done) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, idx[PosW-1:0], z};
            m_tlast  <= (idx + CW'(1) == n);
            state    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (idx + CW'(1) == n) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_SUM_RD || state == S_VDIV) begin
        sd <= '0;
      end
    end
  end

  // Results only leave while emitting.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> state == S_EMIT)
    else $error("result word outside emit state");
  // No sample is taken while a window is being worked.
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid)
    else $error("input ready while result pending");
  // The unit is only started from the sequencer's work states.
  assert property (@(posedge clk) disable iff (rst) req.start |-> state != S_IDLE)
    else $error("unit started while idle");
endmodule
`default_nettype wire

/* sv/swz_divsqrt.sv */
// ----------------------------------------------------------------------------
// Shared restoring divide and square root unit
// Divides a 96-bit magnitude by a 64-bit divisor, one quotient bit per cycle,
// or takes the floor square root of a 64-bit value, two radicand bits per
// cycle. The caller handles signs.
// ----------------------------------------------------------------------------
`default_nettype none
module swz_divsqrt (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire swz_pkg::unit_req_t req,
  output swz_pkg::unit_rsp_t     rsp
);
  import swz_pkg::*;

  logic        busy;
  logic        done;
  logic        is_sqrt;
  logic [6:0]  count;
  logic [95:0] num;
  logic [63:0] den;
  logic [64:0] rem;
  logic [63:0] quo;

  logic [64:0] rem_shift;
  logic [65:0] rem_sq;
  logic [65:0] trial_sq;
  logic [65:0] diff_sq;

  // One division step: shift in the next dividend bit and try to subtract.
  assign rem_shift = {rem[63:0], num[95]};
  // One square root step: bring in two radicand bits, trial 4*root+1.
  assign rem_sq   = {rem[63:0], num[95:94]};
  assign trial_sq = {quo, 2'b01};
  assign diff_sq  = rem_sq - trial_sq;

  // Iteration control and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        is_sqrt <= (req.op == OP_SQRT);
        num     <= (req.op == OP_SQRT) ? {req.num[63:0], 32'd0} : req.num;
        den     <= req.den;
        rem     <= '0;
        quo     <= '0;
        count   <= (req.op == OP_SQRT) ? 7'd32 : 7'd96;
      end else if (busy) begin
        if (is_sqrt) begin
          num <= {num[93:0], 2'b00};
          if (!diff_sq[65]) begin
            rem <= diff_sq[64:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sq[64:0];
            quo <= {quo[62:0], 1'b0};
          end
        end else begin
          num <= {num[94:0], 1'b0};
          if (rem_shift >= {1'b0, den}) begin
            rem <= rem_shift - {1'b0, den};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_shift;
            quo <= {quo[62:0], 1'b0};
          end
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done, quo, rem[63:0]};
endmodule
`default_nettype wire
